// ===== src/b64d_pkg.sv =====
// shared types, constants and the character map of the base64url stream decoder
package b64d_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam logic APS_RESET = 1'b1;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic [5:0] VAL_LOWER_BASE = 6'd26;
	localparam logic [5:0] VAL_DIGIT_BASE = 6'd52;
	localparam logic [5:0] VAL_62 = 6'd62;
	localparam logic [5:0] VAL_63 = 6'd63;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_BAD_CHAR = 2'd1,
		STATUS_BAD_LEN  = 2'd2
	} status_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} map_t;

	// one queued item: an optional data byte and an optional closing result
	typedef struct packed {
		logic       has_byte;
		logic [7:0] data;
		logic       has_end;
		status_t    status;
	} rec_t;

	function automatic map_t map_char(input logic [7:0] ch, input logic aps);
		map_t m;
		m.ok = 1'b1;
		m.val = 6'd0;
		priority if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
			m.val = 6'(ch - CH_UPPER_A);
		end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
			m.val = 6'(ch - CH_LOWER_A) + VAL_LOWER_BASE;
		end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
			m.val = 6'(ch - CH_DIGIT_0) + VAL_DIGIT_BASE;
		end else if (ch == CH_MINUS || (aps && ch == CH_PLUS)) begin
			m.val = VAL_62;
		end else if (ch == CH_UNDERSCORE || (aps && ch == CH_SLASH)) begin
			m.val = VAL_63;
		end else begin
			m.ok = 1'b0;
		end
		return m;
	endfunction

endpackage

// ===== src/base64url_stream_decoder.sv =====
// top level of the base64url stream decoder
// path: a result goes through the queue and then the output register; the closing
//   result that follows a data byte of the same character is offered after that byte
// throughput: one character per cycle unless stalled; the single output register
//   moves one result a cycle unless stalled, so a character's byte and close go in turn
// reset: arst_n clears the bit packing state, the queue and the output; plus/slash on
module base64url_stream_decoder #(
	parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write_en,
	input  logic       cfg_write_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       string_end,
	output logic [1:0] status
);

	logic           accept;
	logic           push;
	logic           pop;
	logic           full;
	logic           empty;
	b64d_pkg::rec_t push_rec;
	b64d_pkg::rec_t head_rec;

	assign in_stall = full;
	assign accept = in_valid & ~full;

	b64d_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.accept        (accept),
		.in_char       (in_char),
		.last_char     (last_char),
		.push          (push),
		.push_rec      (push_rec)
	);

	b64d_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_rec(push_rec),
		.pop     (pop),
		.head_rec(head_rec),
		.full    (full),
		.empty   (empty)
	);

	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_rec  (head_rec),
		.empty     (empty),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.byte_valid(byte_valid),
		.string_end(string_end),
		.status    (status)
	);

endmodule

// ===== src/b64d_front.sv =====
// front part: takes characters, maps them and packs bits into queue items
module b64d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write_en,
	input  logic              cfg_write_data,
	input  logic              accept,
	input  logic [7:0]        in_char,
	input  logic              last_char,
	output logic              push,
	output b64d_pkg::rec_t    push_rec
);

	logic       aps_q;
	logic [5:0] lo_q;
	logic [1:0] pos_q;
	logic       err_q;

	b64d_pkg::map_t m;
	logic           err_next;
	logic           has_byte;
	logic [7:0]     data;
	logic [5:0]     lo_next;
	logic [1:0]     pos_next;

	always_comb begin
		m = b64d_pkg::map_char(in_char, aps_q);
		err_next = err_q | ~m.ok;
		data = 8'd0;
		lo_next = lo_q;
		unique case (pos_q)
			2'd0: begin
				lo_next = m.val;
			end
			2'd1: begin
				data = {lo_q, m.val[5:4]};
				lo_next = {2'b00, m.val[3:0]};
			end
			2'd2: begin
				data = {lo_q[3:0], m.val[5:2]};
				lo_next = {4'b0000, m.val[1:0]};
			end
			default: begin
				data = {lo_q[1:0], m.val};
				lo_next = 6'd0;
			end
		endcase
		has_byte = ~err_next && (pos_q != 2'd0);
		pos_next = pos_q + 2'd1;

		push_rec.has_byte = has_byte;
		push_rec.data = has_byte ? data : 8'd0;
		push_rec.has_end = last_char;
		// a bad character outranks a lone trailing character
		priority if (err_next) begin
			push_rec.status = b64d_pkg::STATUS_BAD_CHAR;
		end else if (pos_q == 2'd0) begin
			push_rec.status = b64d_pkg::STATUS_BAD_LEN;
		end else begin
			push_rec.status = b64d_pkg::STATUS_OK;
		end
		if (!last_char) begin
			push_rec.status = b64d_pkg::STATUS_OK;
		end
		push = accept && (has_byte || last_char);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aps_q <= b64d_pkg::APS_RESET;
		end else if (cfg_write_en) begin
			aps_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= 6'd0;
			pos_q <= 2'd0;
			err_q <= 1'b0;
		end else if (accept) begin
			if (last_char) begin
				lo_q <= 6'd0;
				pos_q <= 2'd0;
				err_q <= 1'b0;
			end else begin
				lo_q <= err_next ? lo_q : lo_next;
				pos_q <= pos_next;
				err_q <= err_next;
			end
		end
	end

endmodule

// ===== src/b64d_queue.sv =====
// short register queue between the front and back parts
module b64d_queue #(
	parameter int unsigned DEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64d_pkg::rec_t push_rec,
	input  logic           pop,
	output b64d_pkg::rec_t head_rec,
	output logic           full,
	output logic           empty
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	b64d_pkg::rec_t  entries_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == CW'(0));
	assign head_rec = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== src/b64d_back.sv =====
// back part: turns queue items into data-byte and closing results
module b64d_back (
	input  logic           clk,
	input  logic           arst_n,
	input  b64d_pkg::rec_t head_rec,
	input  logic           empty,
	output logic           pop,
	input  logic           out_stall,
	output logic           out_valid,
	output logic [7:0]     out_byte,
	output logic           byte_valid,
	output logic           string_end,
	output logic [1:0]     status
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       byte_valid_q;
	logic       string_end_q;
	logic [1:0] status_q;
	logic       byte_done_q;

	logic out_free;
	logic load;
	logic send_byte;

	assign out_free = ~out_valid_q | ~out_stall;
	assign load = out_free & ~empty;
	// byte first, closing result on a later cycle
	assign send_byte = head_rec.has_byte & ~byte_done_q;
	assign pop = load & ~(send_byte & head_rec.has_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			byte_done_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= ~empty;
			end
			if (load) begin
				byte_done_q <= send_byte & head_rec.has_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= send_byte ? head_rec.data : 8'd0;
			byte_valid_q <= send_byte;
			string_end_q <= ~send_byte;
			status_q <= send_byte ? b64d_pkg::STATUS_OK : head_rec.status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign string_end = string_end_q;
	assign status = status_q;

endmodule

// ===== src/b64d_checker.sv =====
// port-level checks on the decoder outputs, bound to the top level
module b64d_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       string_end,
	input logic [1:0] status
);

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) &&
		$stable(byte_valid) && $stable(string_end) && $stable(status))
		else $error("output item changed while stalled");

	// every result carries either a byte or the close, never both
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (byte_valid != string_end))
		else $error("result is neither a byte nor a close, or both");

	a_byte_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid |-> status == b64d_pkg::STATUS_OK)
		else $error("data byte with nonzero status");

	a_close_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_end |-> out_byte == 8'd0 &&
		(status == b64d_pkg::STATUS_OK || status == b64d_pkg::STATUS_BAD_CHAR ||
		status == b64d_pkg::STATUS_BAD_LEN))
		else $error("malformed closing result");

endmodule

bind base64url_stream_decoder b64d_checker u_b64d_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.byte_valid(byte_valid),
	.string_end(string_end),
	.status    (status)
);
